// ----- src/w2rgb_pkg.sv -----
`default_nettype none

package w2rgb_pkg;

	localparam int GAMMA_TENTHS_DEF   = 8;
	localparam int FRAC_BITS_DEF      = 4;
	localparam int INTENSITY_BITS_DEF = 10;

	localparam int Q12_BITS = 12;
	localparam int RAMP_W   = 13;
	localparam int DIST_W   = 14;
	localparam int NUM_W    = 19;
	localparam int DIV_W    = 7;
	localparam int RECIP_SHIFT = 24;
	localparam int RECIP_W  = 20;
	localparam int BIG_W    = 512;

	localparam logic [RAMP_W-1:0] ONE_Q12  = 13'd4096;
	localparam logic [RAMP_W-1:0] DIM_BASE = 13'd1229;
	localparam logic [11:0]       DIM_SPAN = 12'd2867;

	localparam logic [DIV_W-1:0] DIV_VIOLET = 7'd60;
	localparam logic [DIV_W-1:0] DIV_BLUE   = 7'd50;
	localparam logic [DIV_W-1:0] DIV_CYAN   = 7'd20;
	localparam logic [DIV_W-1:0] DIV_GREEN  = 7'd70;
	localparam logic [DIV_W-1:0] DIV_ORANGE = 7'd65;
	localparam logic [DIV_W-1:0] DIV_DIM_HI = 7'd80;
	localparam logic [DIV_W-1:0] DIV_DIM_LO = 7'd40;

	localparam logic [RECIP_W-1:0] RECIP_VIOLET = RECIP_W'((1 << RECIP_SHIFT) / 60);
	localparam logic [RECIP_W-1:0] RECIP_BLUE   = RECIP_W'((1 << RECIP_SHIFT) / 50);
	localparam logic [RECIP_W-1:0] RECIP_CYAN   = RECIP_W'((1 << RECIP_SHIFT) / 20);
	localparam logic [RECIP_W-1:0] RECIP_GREEN  = RECIP_W'((1 << RECIP_SHIFT) / 70);
	localparam logic [RECIP_W-1:0] RECIP_ORANGE = RECIP_W'((1 << RECIP_SHIFT) / 65);
	localparam logic [RECIP_W-1:0] RECIP_DIM_HI = RECIP_W'((1 << RECIP_SHIFT) / 80);
	localparam logic [RECIP_W-1:0] RECIP_DIM_LO = RECIP_W'((1 << RECIP_SHIFT) / 40);

	typedef enum logic [2:0] {
		BAND_DARK,
		BAND_VIOLET,
		BAND_BLUE,
		BAND_CYAN,
		BAND_GREEN,
		BAND_ORANGE,
		BAND_RED
	} band_t;

	typedef struct packed {
		logic st_a;
		logic st_b;
	} adv2_t;

	// largest c with (c/255)^10 <= (idx/2^ib)^g, on exact integers
	function automatic logic [7:0] gamma_level(input int unsigned idx, input int unsigned ib,
		input int unsigned g);
		logic [BIG_W-1:0] rhs;
		logic [BIG_W-1:0] lhs;
		int unsigned lo;
		int unsigned hi;
		int unsigned mid;
		rhs = BIG_W'(1);
		for (int unsigned k = 0; k < g; k++) begin
			rhs = rhs * BIG_W'(idx);
		end
		for (int k = 0; k < 10; k++) begin
			rhs = rhs * BIG_W'(255);
		end
		lo = 0;
		hi = 255;
		while (lo < hi) begin
			mid = (lo + hi + 1) >> 1;
			lhs = BIG_W'(1);
			for (int k = 0; k < 10; k++) begin
				lhs = lhs * BIG_W'(mid);
			end
			lhs = lhs << (ib * g);
			if (lhs <= rhs) begin
				lo = mid;
			end else begin
				hi = mid - 1;
			end
		end
		return lo[7:0];
	endfunction

endpackage

`default_nettype wire

// ----- src/w2rgb_cdiv.sv -----
`default_nettype none

module w2rgb_cdiv (
	input  logic                             clk,
	input  w2rgb_pkg::adv2_t                 adv,
	input  logic [w2rgb_pkg::NUM_W-1:0]      num,
	input  logic [w2rgb_pkg::DIV_W-1:0]      dvsr,
	input  logic [w2rgb_pkg::RECIP_W-1:0]    recip,
	output logic [w2rgb_pkg::RAMP_W-1:0]     quot
);
	import w2rgb_pkg::*;

	localparam int PROD_W = NUM_W + RECIP_W;

	logic [PROD_W-1:0] prod_s2;
	logic [NUM_W-1:0]  num_s2;
	logic [DIV_W-1:0]  dvsr_s2;
	logic [RAMP_W-1:0] est;
	logic [NUM_W-1:0]  rem;
	logic [RAMP_W-1:0] quot_s3;

	always_ff @(posedge clk) begin
		if (adv.st_a) begin
			prod_s2 <= PROD_W'(num) * PROD_W'(recip);
			num_s2  <= num;
			dvsr_s2 <= dvsr;
		end
	end

	// estimate is exact or one short
	assign est = prod_s2[RECIP_SHIFT +: RAMP_W];
	assign rem = num_s2 - NUM_W'(est) * NUM_W'(dvsr_s2);

	always_ff @(posedge clk) begin
		if (adv.st_b) begin
			quot_s3 <= (rem >= NUM_W'(dvsr_s2)) ? est + RAMP_W'(1) : est;
		end
	end

	assign quot = quot_s3;

endmodule

`default_nettype wire

// ----- src/w2rgb_gamma.sv -----
`default_nettype none

module w2rgb_gamma #(
	parameter int INTENSITY_BITS = w2rgb_pkg::INTENSITY_BITS_DEF,
	parameter int GAMMA_TENTHS   = w2rgb_pkg::GAMMA_TENTHS_DEF
) (
	input  logic                           clk,
	input  w2rgb_pkg::adv2_t               adv,
	input  logic [2:0][INTENSITY_BITS:0]   idx,    // [0] blue, [1] green, [2] red
	output logic [2:0][7:0]                level   // [0] blue, [1] green, [2] red
);
	import w2rgb_pkg::*;

	localparam int IDX_W    = INTENSITY_BITS + 1;
	localparam int TBL_SIZE = (1 << INTENSITY_BITS) + 1;
	localparam int SUB_W    = (INTENSITY_BITS < 8) ? INTENSITY_BITS : 8;
	localparam int HI_W     = IDX_W - SUB_W;
	localparam int N_SUB    = (1 << (INTENSITY_BITS - SUB_W)) + 1;
	localparam int ROM_N    = N_SUB << SUB_W;

	logic [7:0] rom [ROM_N];

	for (genvar j = 0; j < ROM_N; j++) begin : g_rom
		if (j < TBL_SIZE) begin : g_lvl
			localparam logic [7:0] LVL = gamma_level(j, INTENSITY_BITS, GAMMA_TENTHS);
			assign rom[j] = LVL;
		end else begin : g_sat
			assign rom[j] = 8'hff;
		end
	end

	logic [7:0]            sub_d  [3][N_SUB];
	logic [7:0]            sub_s5 [3][N_SUB];
	logic [2:0][HI_W-1:0]  hi_s5;
	logic [2:0][7:0]       level_s6;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			for (int j = 0; j < N_SUB; j++) begin
				sub_d[c][j] = rom[{HI_W'(j), idx[c][SUB_W-1:0]}];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv.st_a) begin
			sub_s5 <= sub_d;
			for (int c = 0; c < 3; c++) begin
				hi_s5[c] <= idx[c][IDX_W-1:SUB_W];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv.st_b) begin
			for (int c = 0; c < 3; c++) begin
				level_s6[c] <= (int'(hi_s5[c]) < N_SUB) ? sub_s5[c][hi_s5[c]] : 8'hff;
			end
		end
	end

	assign level = level_s6;

endmodule

`default_nettype wire

// ----- src/wavelength_to_rgb.sv -----
// Wavelength to packed RGB colour map, six register stages.
// Stages: an accepted item moves through s1 to s6 in order; m_tvalid is the s6 valid bit.
// Throughput: one item per cycle when no stage is stalled; every stage holds under back-pressure.
// Reset: arst_n clears all stage valid bits at once and drops any item in flight.
// The gamma table is a constant built at elaboration; no fill after reset.
`default_nettype none

module wavelength_to_rgb #(
	parameter int GAMMA_TENTHS   = w2rgb_pkg::GAMMA_TENTHS_DEF,
	parameter int FRAC_BITS      = w2rgb_pkg::FRAC_BITS_DEF,
	parameter int INTENSITY_BITS = w2rgb_pkg::INTENSITY_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,    // [13:0] wavelength_q4
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata     // [23:0] packed_rgb
);
	import w2rgb_pkg::*;

	localparam logic [31:0] NM_380 = 32'(380) << FRAC_BITS;
	localparam logic [31:0] NM_420 = 32'(420) << FRAC_BITS;
	localparam logic [31:0] NM_440 = 32'(440) << FRAC_BITS;
	localparam logic [31:0] NM_490 = 32'(490) << FRAC_BITS;
	localparam logic [31:0] NM_510 = 32'(510) << FRAC_BITS;
	localparam logic [31:0] NM_580 = 32'(580) << FRAC_BITS;
	localparam logic [31:0] NM_645 = 32'(645) << FRAC_BITS;
	localparam logic [31:0] NM_700 = 32'(700) << FRAC_BITS;
	localparam logic [31:0] NM_780 = 32'(780) << FRAC_BITS;
	localparam int RAW_W = DIST_W + Q12_BITS;
	localparam int IDX_W = INTENSITY_BITS + 1;

	logic en1, en2, en3, en4, en5, en6;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic [DIST_W-1:0]  wl;
	band_t              band_d;
	logic [DIST_W-1:0]  rdist_d;
	logic [DIV_W-1:0]   rdiv_d;
	logic [RECIP_W-1:0] rrecip_d;
	logic               dim_d;
	logic [DIST_W-1:0]  fdist_d;
	logic [DIV_W-1:0]   fdiv_d;
	logic [RECIP_W-1:0] frecip_d;
	logic [RAW_W-1:0]   rnum_raw;
	logic [RAW_W-1:0]   fprod;

	band_t              band_s1, band_s2, band_s3;
	logic               dim_s1, dim_s2, dim_s3;
	logic [NUM_W-1:0]   rnum_s1, fnum_s1;
	logic [DIV_W-1:0]   rdiv_s1, fdiv_s1;
	logic [RECIP_W-1:0] rrecip_s1, frecip_s1;

	logic [RAMP_W-1:0]  ramp_s3, fq_s3;
	logic [RAMP_W-1:0]  fac;
	logic [2:0][RAMP_W-1:0] ch;
	logic [2*RAMP_W-1:0] chp [3];
	logic [2:0][IDX_W-1:0] idx_s4;
	logic [2:0][7:0]    level_s6;

	adv2_t div_adv, lut_adv;

	assign en6 = !v_s6 || m_tready;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;

	assign s_tready = en1;
	assign m_tvalid = v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en1) v_s1 <= s_tvalid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

	assign wl = s_tdata[DIST_W-1:0];

	always_comb begin
		band_d   = BAND_DARK;
		rdist_d  = '0;
		rdiv_d   = DIV_ORANGE;
		rrecip_d = RECIP_ORANGE;
		if (32'(wl) < NM_380 || 32'(wl) > NM_780) begin
			band_d = BAND_DARK;
		end else if (32'(wl) <= NM_490) begin
			if (32'(wl) < NM_440) begin
				band_d   = BAND_VIOLET;
				rdist_d  = DIST_W'(NM_440 - 32'(wl));
				rdiv_d   = DIV_VIOLET;
				rrecip_d = RECIP_VIOLET;
			end else begin
				band_d   = BAND_BLUE;
				rdist_d  = DIST_W'(32'(wl) - NM_440);
				rdiv_d   = DIV_BLUE;
				rrecip_d = RECIP_BLUE;
			end
		end else if (32'(wl) <= NM_580) begin
			if (32'(wl) < NM_510) begin
				band_d   = BAND_CYAN;
				rdist_d  = DIST_W'(NM_510 - 32'(wl));
				rdiv_d   = DIV_CYAN;
				rrecip_d = RECIP_CYAN;
			end else begin
				band_d   = BAND_GREEN;
				rdist_d  = DIST_W'(32'(wl) - NM_510);
				rdiv_d   = DIV_GREEN;
				rrecip_d = RECIP_GREEN;
			end
		end else if (32'(wl) < NM_645) begin
			band_d  = BAND_ORANGE;
			rdist_d = DIST_W'(NM_645 - 32'(wl));
		end else begin
			band_d = BAND_RED;
		end

		dim_d    = 1'b1;
		fdist_d  = '0;
		fdiv_d   = DIV_DIM_HI;
		frecip_d = RECIP_DIM_HI;
		if (32'(wl) > NM_700) begin
			fdist_d = DIST_W'(NM_780 - 32'(wl));
		end else if (32'(wl) < NM_420) begin
			fdist_d  = DIST_W'(32'(wl) - NM_380);
			fdiv_d   = DIV_DIM_LO;
			frecip_d = RECIP_DIM_LO;
		end else begin
			dim_d = 1'b0;
		end
	end

	assign rnum_raw = {rdist_d, Q12_BITS'(0)} >> FRAC_BITS;
	assign fprod    = RAW_W'(DIM_SPAN) * RAW_W'(fdist_d);

	always_ff @(posedge clk) begin
		if (en1) begin
			band_s1   <= band_d;
			dim_s1    <= dim_d;
			rnum_s1   <= NUM_W'(rnum_raw);
			rdiv_s1   <= rdiv_d;
			rrecip_s1 <= rrecip_d;
			fnum_s1   <= NUM_W'(fprod >> FRAC_BITS);
			fdiv_s1   <= fdiv_d;
			frecip_s1 <= frecip_d;
		end
		if (en2) begin
			band_s2 <= band_s1;
			dim_s2  <= dim_s1;
		end
		if (en3) begin
			band_s3 <= band_s2;
			dim_s3  <= dim_s2;
		end
	end

	assign div_adv.st_a = en2;
	assign div_adv.st_b = en3;

	w2rgb_cdiv u_ramp_div (
		.clk   (clk),
		.adv   (div_adv),
		.num   (rnum_s1),
		.dvsr  (rdiv_s1),
		.recip (rrecip_s1),
		.quot  (ramp_s3)
	);

	w2rgb_cdiv u_dim_div (
		.clk   (clk),
		.adv   (div_adv),
		.num   (fnum_s1),
		.dvsr  (fdiv_s1),
		.recip (frecip_s1),
		.quot  (fq_s3)
	);

	assign fac = dim_s3 ? DIM_BASE + fq_s3 : ONE_Q12;

	always_comb begin
		case (band_s3)
			BAND_VIOLET: ch = {ramp_s3, RAMP_W'(0), ONE_Q12};
			BAND_BLUE:   ch = {RAMP_W'(0), ramp_s3, ONE_Q12};
			BAND_CYAN:   ch = {RAMP_W'(0), ONE_Q12, ramp_s3};
			BAND_GREEN:  ch = {ramp_s3, ONE_Q12, RAMP_W'(0)};
			BAND_ORANGE: ch = {ONE_Q12, ramp_s3, RAMP_W'(0)};
			BAND_RED:    ch = {ONE_Q12, RAMP_W'(0), RAMP_W'(0)};
			default:     ch = '0;
		endcase
		for (int c = 0; c < 3; c++) begin
			chp[c] = (2*RAMP_W)'(ch[c]) * (2*RAMP_W)'(fac);
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			for (int c = 0; c < 3; c++) begin
				idx_s4[c] <= chp[c][2*Q12_BITS -: IDX_W];
			end
		end
	end

	assign lut_adv.st_a = en5;
	assign lut_adv.st_b = en6;

	w2rgb_gamma #(
		.INTENSITY_BITS (INTENSITY_BITS),
		.GAMMA_TENTHS   (GAMMA_TENTHS)
	) u_gamma (
		.clk   (clk),
		.adv   (lut_adv),
		.idx   (idx_s4),
		.level (level_s6)
	);

	assign m_tdata = level_s6;

	assert property (@(posedge clk) disable iff (!arst_n) m_tready |-> s_tready)
		else $error("pipeline stalled with output ready");

	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && band_s3 != BAND_DARK) |-> (ramp_s3 <= ONE_Q12))
		else $error("ramp above unity");

	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && dim_s3 && band_s3 != BAND_DARK) |-> (fq_s3 <= RAMP_W'(DIM_SPAN)))
		else $error("dimming factor above unity");

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
`default_nettype none

module testbench;

	localparam int GAMMA_T      = 8;
	localparam int FB           = 4;
	localparam int IB           = 10;
	localparam int LUT_TOP      = 1 << IB;
	localparam int RANDOM_ITEMS = 80;
	localparam int HOLD_ITEMS   = 60;
	localparam int HOLD_CYCLES  = 300;
	localparam int IDLE_PCT     = 57;
	localparam int BOTH_PCT     = 24;
	localparam int TAIL_CYCLES  = 20;
	localparam int WATCHDOG_MAX = 5000;

	typedef enum logic [2:0] {
		PH_FREE,
		PH_SRC_IDLE,
		PH_SNK_STALL,
		PH_BOTH,
		PH_HOLD
	} phase_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;     // [13:0] wavelength_q4
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;          // [23:0] packed_rgb

	phase_t      phase = PH_FREE;
	logic [13:0] wave_q[$];
	logic [23:0] rgb_q[$];
	logic [7:0]  gamma_lut [0:LUT_TOP];
	int          hold_cnt = 0;
	int          idle_cnt = 0;
	int          errors = 0;
	int          n_sent = 0;
	int          n_checked = 0;

	wavelength_to_rgb u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// largest level c with (c/255)^10 <= (i/2^IB)^GAMMA_T, exact integers
	function automatic logic [7:0] gamma_entry(input int unsigned i);
		logic [191:0] rhs;
		logic [191:0] lhs;
		int unsigned lo;
		int unsigned hi;
		int unsigned mid;
		rhs = 192'd1;
		for (int k = 0; k < GAMMA_T; k++) rhs = rhs * 192'(i);
		for (int k = 0; k < 10; k++) rhs = rhs * 192'd255;
		lo = 0;
		hi = 255;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			lhs = 192'd1;
			for (int k = 0; k < 10; k++) lhs = lhs * 192'(mid);
			lhs = lhs << (IB * GAMMA_T);
			if (lhs <= rhs) begin
				lo = mid;
			end else begin
				hi = mid - 1;
			end
		end
		return lo[7:0];
	endfunction

	function automatic longint unsigned nm(input int unsigned x);
		return 64'(x) << FB;
	endfunction

	function automatic longint unsigned ramp(input longint unsigned span,
		input int unsigned width_nm);
		return (span << 12) / nm(width_nm);
	endfunction

	function automatic logic [7:0] shade(input longint unsigned lvl, input longint unsigned dim);
		longint unsigned v;
		longint unsigned idx;
		v = (lvl * dim) >> 12;
		idx = v >> (12 - IB);
		if (idx > LUT_TOP) idx = LUT_TOP;
		return gamma_lut[idx];
	endfunction

	function automatic logic [23:0] wave_color(input logic [13:0] wl);
		longint unsigned w;
		longint unsigned r;
		longint unsigned g;
		longint unsigned b;
		longint unsigned f;
		w = 64'(wl);
		if (w < nm(380) || w > nm(780)) return 24'h000000;
		if (w <= nm(490)) begin
			if (w < nm(440)) begin
				r = ramp(nm(440) - w, 60);
				g = 0;
			end else begin
				r = 0;
				g = ramp(w - nm(440), 50);
			end
			b = 4096;
		end else if (w <= nm(580)) begin
			if (w < nm(510)) begin
				r = 0;
				b = ramp(nm(510) - w, 20);
			end else begin
				r = ramp(w - nm(510), 70);
				b = 0;
			end
			g = 4096;
		end else begin
			r = 4096;
			g = (w < nm(645)) ? ramp(nm(645) - w, 65) : 0;
			b = 0;
		end
		if (w > nm(700)) begin
			f = 1229 + (2867 * (nm(780) - w)) / nm(80);
		end else if (w < nm(420)) begin
			f = 1229 + (2867 * (w - nm(380))) / nm(40);
		end else begin
			f = 4096;
		end
		return {shade(r, f), shade(g, f), shade(b, f)};
	endfunction

	function automatic int src_idle_pct(input phase_t ph);
		case (ph)
			PH_SRC_IDLE: return IDLE_PCT;
			PH_BOTH:     return BOTH_PCT;
			default:     return 0;
		endcase
	endfunction

	function automatic int snk_stall_pct(input phase_t ph);
		case (ph)
			PH_SNK_STALL: return IDLE_PCT;
			PH_BOTH:      return BOTH_PCT;
			default:      return 0;
		endcase
	endfunction

	function automatic logic [13:0] rand_wave();
		if ($urandom_range(99) < 80) begin
			return 14'($urandom_range(6080, 12480));
		end
		return 14'($urandom_range(16383));
	endfunction

	always @(posedge clk) begin : driver
		logic go;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				rgb_q.push_back(wave_color(s_tdata[13:0]));
				n_sent++;
			end
			if (!s_tvalid || s_tready) begin
				go = wave_q.size() != 0 && $urandom_range(99) >= src_idle_pct(phase);
				if (go) begin
					s_tvalid <= 1'b1;
					s_tdata  <= {2'b00, wave_q.pop_front()};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : receiver
		if (phase == PH_HOLD && hold_cnt < HOLD_CYCLES) begin
			m_tready <= 1'b0;
			hold_cnt <= hold_cnt + 1;
		end else begin
			m_tready <= $urandom_range(99) >= snk_stall_pct(phase);
		end
	end

	always @(posedge clk) begin : monitor
		logic [23:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (rgb_q.size() == 0) begin
				$error("unexpected item: packed_rgb actual %06h", m_tdata);
				errors++;
			end else begin
				want = rgb_q.pop_front();
				n_checked++;
				if (m_tdata !== want) begin
					$error("packed_rgb mismatch: expected %06h, actual %06h", want, m_tdata);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cnt <= 0;
			end else begin
				idle_cnt <= idle_cnt + 1;
			end
			if (idle_cnt >= WATCHDOG_MAX) begin
				$display("timeout: no item moved for %0d cycles", WATCHDOG_MAX);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	task automatic drain();
		while (wave_q.size() != 0 || s_tvalid || rgb_q.size() != 0) @(negedge clk);
	endtask

	initial begin
		logic [13:0] directed [$];
		for (int i = 0; i <= LUT_TOP; i++) gamma_lut[i] = gamma_entry(i);
		directed = '{14'd0, 14'd16383, 14'd6079, 14'd6080, 14'd6081, 14'd6719, 14'd6720,
			14'd7039, 14'd7040, 14'd7839, 14'd7840, 14'd7841, 14'd8159, 14'd8160,
			14'd9280, 14'd9281, 14'd10319, 14'd10320, 14'd11200, 14'd11201,
			14'd12479, 14'd12480, 14'd12481, 14'h2AAA, 14'h1555};
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed[i]) wave_q.push_back(directed[i]);
		for (int p = PH_FREE; p <= PH_BOTH; p++) begin
			phase = phase_t'(p);
			for (int i = 0; i < RANDOM_ITEMS; i++) wave_q.push_back(rand_wave());
			drain();
		end

		phase = PH_HOLD;
		for (int i = 0; i < HOLD_ITEMS; i++) wave_q.push_back(rand_wave());
		drain();

		repeat (TAIL_CYCLES) @(negedge clk);
		$display("%0d wavelengths sent across free-running, stalled and held-off traffic,",
			n_sent);
		$display("%0d colors compared, %0d mismatches", n_checked, errors);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ----- files.f -----
src/w2rgb_pkg.sv
src/w2rgb_cdiv.sv
src/w2rgb_gamma.sv
src/wavelength_to_rgb.sv
sim/testbench.sv
